// ===== sv/pnsg_pkg.sv =====
package pnsg_pkg;

    localparam int PN_W          = 62;
    localparam int RND_W         = 16;
    localparam int GAP_W         = 16;
    localparam int PROD_W        = RND_W + GAP_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int OFF_W         = 17;
    localparam int DIV_SHIFT     = 15;
    localparam int CNT_OUT_W     = 4;
    localparam int REMEMBERED_SKIPS_DEF = 10;

    localparam logic [PROD_W-1:0] RANGE_DIV = PROD_W'(32'h7FFF);
    localparam logic [GAP_W-1:0]  GAP_RESET = GAP_W'(1);

    localparam logic MODE_NEXT   = 1'b0;
    localparam logic MODE_RESEED = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [RND_W-1:0] random_value;
    } t_in_beat;

    typedef struct packed {
        logic [PN_W-1:0]      handed_number;
        logic                 skipped_valid;
        logic [PN_W-1:0]      skipped_number;
        logic [CNT_OUT_W-1:0] remembered_count;
    } t_out_beat;

    typedef struct packed {
        logic             mode;
        logic [OFF_W-1:0] offset;
    } t_off_beat;

endpackage

// ===== sv/pnsg_offset.sv =====
module pnsg_offset
    import pnsg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [GAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_beat,
    output logic             o_off_valid,
    input  logic             i_off_stall,
    output t_off_beat        o_off_beat
);

    logic [GAP_W-1:0]  r_gap;
    logic [GAP_W-1:0]  gap_m1;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic              en1, en2, en3, en4;
    logic              r_mode1, r_mode2, r_mode3, r_mode4;
    logic [RND_W-1:0]  r_rnd1;
    logic [PROD_W-1:0] r_prod2, r_prod3;
    logic [OFF_W-1:0]  r_q3, r_off4;

    logic [SUM_W-1:0]  sum;
    logic [OFF_W-1:0]  n_q3;
    logic [PROD_W-1:0] q_times_div;
    logic [PROD_W-1:0] rem;
    logic [OFF_W-1:0]  n_off4;

    assign en4 = !r_v4 || !i_off_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_stall = !en1;

    assign gap_m1 = (r_gap == '0) ? '0 : r_gap - GAP_W'(1);

    // floor(p / 0x7FFF) via p * (2^-15 + 2^-30 + 2^-45), at most one short
    assign sum  = SUM_W'(r_prod2) + SUM_W'(r_prod2 >> DIV_SHIFT)
                + SUM_W'(r_prod2 >> (2 * DIV_SHIFT));
    assign n_q3 = sum[DIV_SHIFT +: OFF_W];

    assign q_times_div = (PROD_W'(r_q3) << DIV_SHIFT) - PROD_W'(r_q3);
    assign rem         = r_prod3 - q_times_div;
    assign n_off4      = (rem >= RANGE_DIV) ? r_q3 + OFF_W'(1) : r_q3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_gap <= i_cfg_data;
            end
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_mode1 <= i_in_beat.mode;
            r_rnd1  <= i_in_beat.random_value;
        end
        if (en2) begin
            r_mode2 <= r_mode1;
            r_prod2 <= PROD_W'(r_rnd1) * PROD_W'(gap_m1);
        end
        if (en3) begin
            r_mode3 <= r_mode2;
            r_prod3 <= r_prod2;
            r_q3    <= n_q3;
        end
        if (en4) begin
            r_mode4 <= r_mode3;
            r_off4  <= n_off4;
        end
    end

    assign o_off_valid       = r_v4;
    assign o_off_beat.mode   = r_mode4;
    assign o_off_beat.offset = r_off4;

endmodule

// ===== sv/pnsg_counter.sv =====
module pnsg_counter
    import pnsg_pkg::*;
#(
    parameter int REMEMBERED_SKIPS = REMEMBERED_SKIPS_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_off_valid,
    output logic      o_off_stall,
    input  t_off_beat i_off_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int CNT_W = $clog2(REMEMBERED_SKIPS + 1);

    logic             r_valid;
    logic [PN_W-1:0]  r_next, n_next;
    logic [PN_W-1:0]  r_skip, n_skip;
    logic [CNT_W-1:0] r_count, n_count;
    t_out_beat        r_beat, n_beat;

    logic             en_out;
    logic             take;
    logic             hit;
    logic             draw;
    logic [PN_W-1:0]  pn_plus1;
    logic [PN_W-1:0]  draw_base;
    logic [CNT_W+CNT_OUT_W-1:0] count_ext;

    assign en_out      = !r_valid || !i_out_stall;
    assign o_off_stall = !en_out;
    assign take        = i_off_valid && en_out;

    always_comb begin
        pn_plus1  = r_next + PN_W'(1);
        hit       = (i_off_beat.mode == MODE_NEXT) && (pn_plus1 == r_skip);
        draw      = hit || (i_off_beat.mode == MODE_RESEED);
        draw_base = hit ? r_next + PN_W'(4) : r_next + PN_W'(2);

        n_next = r_next;
        if (i_off_beat.mode == MODE_NEXT) begin
            n_next = hit ? r_next + PN_W'(2) : pn_plus1;
        end
        n_skip  = draw ? draw_base + PN_W'(i_off_beat.offset) : r_skip;

        n_count = r_count;
        if (hit) begin
            // hold at full
            n_count = (r_count >= CNT_W'(REMEMBERED_SKIPS)) ? CNT_W'(REMEMBERED_SKIPS)
                                                           : r_count + CNT_W'(1);
        end
        count_ext = (CNT_W + CNT_OUT_W)'(n_count);

        n_beat.handed_number    = r_next;
        n_beat.skipped_valid    = hit;
        n_beat.skipped_number   = hit ? pn_plus1 : '0;
        n_beat.remembered_count = count_ext[CNT_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_next  <= '0;
            r_skip  <= '0;
            r_count <= '0;
        end else begin
            if (en_out) begin
                r_valid <= i_off_valid;
            end
            if (take) begin
                r_next  <= n_next;
                r_skip  <= n_skip;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_beat <= n_beat;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

    a_skip_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.skipped_valid) |->
        (o_out_beat.skipped_number == o_out_beat.handed_number + PN_W'(1)))
        else $error("skipped number not one past the handed number");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.skipped_valid) |->
        (o_out_beat.skipped_number == '0))
        else $error("skipped number set without a skip");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(REMEMBERED_SKIPS))
        else $error("ring occupancy above its depth");

    a_next_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_off_beat.mode == MODE_NEXT) |=> (r_next != $past(r_next)))
        else $error("next number did not advance");

endmodule

// ===== sv/packet_number_skip_generator_unit.sv =====
// channel  direction  handshake             payload
// in       input      i_in_valid/o_in_stall  i_in_beat  (t_in_beat)
// out      output     o_out_valid/i_out_stall o_out_beat (t_out_beat)
// cfg      input      i_cfg_valid/o_cfg_ready i_cfg_data (average_gap)
//
// One beat accepted per cycle while o_in_stall is low. Each beat passes through the offset
// pipeline registers in order: input register, multiply, reciprocal estimate, correction;
// then the counter update registers the result.
// Synchronous active-low reset clears counter, skip point and occupancy.
// A stall on the output only backs up as far as the pipeline is full.
module packet_number_skip_generator_unit
    import pnsg_pkg::*;
#(
    parameter int REMEMBERED_SKIPS = REMEMBERED_SKIPS_DEF
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [GAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_beat,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out_beat
);

    logic      off_valid;
    logic      off_stall;
    t_off_beat off_beat;

    assign o_cfg_ready = 1'b1;

    pnsg_offset u_offset (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_off_valid (off_valid),
        .i_off_stall (off_stall),
        .o_off_beat  (off_beat)
    );

    pnsg_counter #(
        .REMEMBERED_SKIPS (REMEMBERED_SKIPS)
    ) u_counter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_off_valid (off_valid),
        .o_off_stall (off_stall),
        .i_off_beat  (off_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
